// File: hw/rtl/triangle_slab_clipper_macros.svh
// assertion macros for the slab clipper
`ifndef TRIANGLE_SLAB_CLIPPER_MACROS_SVH
`define TRIANGLE_SLAB_CLIPPER_MACROS_SVH
// property a implies b on the next clock
`define TSC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
// property a implies b on the same clock
`define TSC_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
`endif

// File: hw/rtl/tsc_pkg.sv
// shared types and constants for the slab clipper
`timescale 1ns / 1ps
package tsc_pkg;
  localparam int CoordBits = 16;
  localparam int ProdBits = 2 * (CoordBits + 1);
  localparam int MagBits = CoordBits + 1;
  localparam int QuoBits = ProdBits;
  localparam int QCntBits = $clog2(QuoBits + 1);
  localparam int NumLanes = 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits+1:0] wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;

  typedef struct packed {
    logic start;
    vtx_t f;
    vtx_t o;
    coord_t plane;
  } xreq_t;

  typedef struct packed {
    logic done;
    vtx_t p;
  } xrsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOW,
    ST_UPPER,
    ST_EMIT
  } state_t;

  localparam logic [1:0] RegLower = 2'd0;
  localparam logic [1:0] RegUpper = 2'd1;
  localparam coord_t UpperReset = coord_t'(1 <<< (CoordBits - 3));
endpackage

// File: hw/rtl/tsc_cross.sv
// one crossing lane: multiply then restoring divide, one quotient bit per cycle
`timescale 1ns / 1ps
module tsc_cross (
  input  logic           clk,
  input  logic           rst,
  input  tsc_pkg::xreq_t req,
  output tsc_pkg::xrsp_t rsp
);
  import tsc_pkg::*;
  `include "triangle_slab_clipper_macros.svh"

  logic                busy;
  logic                mul_phase;
  logic [ProdBits-1:0] num;
  logic [MagBits-1:0]  den;
  logic [MagBits:0]    rem;
  logic [QuoBits-1:0]  quo;
  logic [QCntBits-1:0] cnt;
  logic                neg;
  logic                zero_den;
  coord_t              fx;
  coord_t              py;
  logic [MagBits-1:0]  mdx, mdy, mndy;
  wide_t               dx, dy, ndy;
  logic [MagBits:0]    trial;
  logic [MagBits:0]    rem_sh;
  wide_t               qx;
  wide_t               sum;

  always_comb begin
    dx = wide_t'(req.o.x) - wide_t'(req.f.x);
    dy = wide_t'(req.o.y) - wide_t'(req.f.y);
    ndy = wide_t'(req.plane) - wide_t'(req.f.y);
    mdx = dx[CoordBits+1] ? MagBits'(-dx) : MagBits'(dx);
    mdy = dy[CoordBits+1] ? MagBits'(-dy) : MagBits'(dy);
    mndy = ndy[CoordBits+1] ? MagBits'(-ndy) : MagBits'(ndy);
    rem_sh = {rem[MagBits-1:0], num[ProdBits-1]};
    trial = rem_sh - {1'b0, den};
    qx = zero_den ? '0 : wide_t'(quo[CoordBits+1:0]);
    sum = wide_t'(fx) + (neg ? -qx : qx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mul_phase <= 1'b1;
        num <= ProdBits'(mdx) * ProdBits'(mndy);
        den <= mdy;
        zero_den <= (mdy == '0);
        neg <= dx[CoordBits+1] ^ dy[CoordBits+1] ^ ndy[CoordBits+1];
        fx <= req.f.x;
        py <= req.plane;
        rem <= '0;
        quo <= '0;
        cnt <= QCntBits'(QuoBits);
      end else if (busy) begin
        if (cnt != '0) begin
          if (!trial[MagBits]) begin
            rem <= trial;
            quo <= {quo[QuoBits-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[QuoBits-2:0], 1'b0};
          end
          num <= {num[ProdBits-2:0], 1'b0};
          cnt <= cnt - QCntBits'(1);
          mul_phase <= 1'b0;
        end else begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.p.x <= sum[CoordBits-1:0];
          rsp.p.y <= py;
        end
      end
    end
  end

  `TSC_ASSERT_NEXT(a_start_busy, clk, rst, req.start, busy)
  `TSC_ASSERT_NEXT(a_done_idle, clk, rst, rsp.done, !busy || $past(req.start))
  `TSC_ASSERT_NOW(a_no_restart, clk, rst, busy && !mul_phase, !req.start)
endmodule

// File: hw/rtl/triangle_slab_clipper.sv
// slab clipper top level: two crossing lanes, sequencer and output queue
// each clip pass with crossings runs both lanes side by side, each dividing out 34 quotient
// bits one per cycle; a pass without crossings uses no lane
// throughput: one triangle at a time, one lower and up to two upper passes, then up to four
// result beats; a new input triangle is taken only once all result beats have gone out
// rst clears control state and sets the lower plane to 0 and the upper plane to 2**13
`timescale 1ns / 1ps
module triangle_slab_clipper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [1:0]                     addr,
  input  logic [tsc_pkg::CoordBits-1:0]  wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tsc_pkg::coord_t                in_ax,
  input  tsc_pkg::coord_t                in_ay,
  input  tsc_pkg::coord_t                in_bx,
  input  tsc_pkg::coord_t                in_by,
  input  tsc_pkg::coord_t                in_cx,
  input  tsc_pkg::coord_t                in_cy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tsc_pkg::coord_t                out_ax,
  output tsc_pkg::coord_t                out_ay,
  output tsc_pkg::coord_t                out_bx,
  output tsc_pkg::coord_t                out_by,
  output tsc_pkg::coord_t                out_cx,
  output tsc_pkg::coord_t                out_cy,
  output logic                           out_last
);
  import tsc_pkg::*;
  `include "triangle_slab_clipper_macros.svh"

  coord_t lower_plane, upper_plane;
  state_t state, state_next;

  tri_t   work [2];
  logic   [1:0] nwork;
  logic   [1:0] widx;
  tri_t   outq [4];
  logic   [2:0] nout;
  logic   [1:0] ridx;
  logic   [2:0] nfin;

  tri_t   cur;
  coord_t plane;
  logic   up;
  logic   o0, o1, o2;
  logic   [1:0] nin;
  vtx_t   v0, v1, v2, kv, n1, n2;
  logic   waiting;
  xreq_t  req0, req1;
  xrsp_t  rsp0, rsp1;
  tri_t   res0, res1;
  logic   [1:0] nres;

  tsc_cross u_lane0 (.clk(clk), .rst(rst), .req(req0), .rsp(rsp0));
  tsc_cross u_lane1 (.clk(clk), .rst(rst), .req(req1), .rsp(rsp1));

  // classify the triangle under work against the active plane
  always_comb begin
    up = (state == ST_UPPER);
    cur = work[widx[0]];
    plane = up ? upper_plane : lower_plane;
    v0 = cur.a;
    v1 = cur.b;
    v2 = cur.c;
    o0 = up ? (v0.y > plane) : (v0.y < plane);
    o1 = up ? (v1.y > plane) : (v1.y < plane);
    o2 = up ? (v2.y > plane) : (v2.y < plane);
    nin = 2'(!o0) + 2'(!o1) + 2'(!o2);
    kv = v0; n1 = v1; n2 = v2;
    if (nin == 2'd2) begin
      if (o0) begin kv = v0; n1 = v1; n2 = v2; end
      else if (o1) begin kv = v1; n1 = v2; n2 = v0; end
      else begin kv = v2; n1 = v0; n2 = v1; end
    end else begin
      if (!o0) begin kv = v0; n1 = v1; n2 = v2; end
      else if (!o1) begin kv = v1; n1 = v2; n2 = v0; end
      else begin kv = v2; n1 = v0; n2 = v1; end
    end
    // merge of lane results
    res0 = cur;
    res1 = cur;
    nres = 2'd0;
    if (nin == 2'd3) begin
      nres = 2'd1;
    end else if (nin == 2'd2) begin
      res0 = '{a: rsp0.p, b: n1, c: n2};
      res1 = '{a: rsp1.p, b: rsp0.p, c: n2};
      nres = 2'd2;
    end else if (nin == 2'd1) begin
      res0 = '{a: rsp0.p, b: rsp1.p, c: kv};
      nres = 2'd1;
    end
    req0 = '{start: 1'b0, f: (nin == 2'd2) ? n1 : kv,
             o: (nin == 2'd2) ? kv : n1, plane: plane};
    req1 = '{start: 1'b0, f: (nin == 2'd2) ? n2 : kv,
             o: (nin == 2'd2) ? kv : n2, plane: plane};
    if ((state == ST_LOW || state == ST_UPPER) && !waiting && widx < nwork
        && (nin == 2'd1 || nin == 2'd2)) begin
      req0.start = 1'b1;
      req1.start = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_LOW;
      ST_LOW:   if (!waiting && (nin == 2'd0 || nin == 2'd3) || rsp0.done)
                  state_next = ST_UPPER;
      ST_UPPER: if (widx >= nwork) state_next = ST_EMIT;
      ST_EMIT:  if (ridx == nout[1:0] + 2'd0 && nout == 3'd0 ||
                    nfin == nout) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT) && (nfin < nout);
  always_comb begin
    out_ax = outq[ridx].a.x; out_ay = outq[ridx].a.y;
    out_bx = outq[ridx].b.x; out_by = outq[ridx].b.y;
    out_cx = outq[ridx].c.x; out_cy = outq[ridx].c.y;
    out_last = (nfin == nout - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lower_plane <= '0;
      upper_plane <= UpperReset;
      waiting <= 1'b0;
      nwork <= '0; widx <= '0; nout <= '0; ridx <= '0; nfin <= '0;
    end else begin
      state <= state_next;
      if (we) begin
        case (addr)
          RegLower: lower_plane <= wdata;
          RegUpper: upper_plane <= wdata;
          default:  ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            work[0] <= '{a: '{in_ax, in_ay}, b: '{in_bx, in_by}, c: '{in_cx, in_cy}};
            nwork <= 2'd1; widx <= '0; nout <= '0; ridx <= '0; nfin <= '0;
            waiting <= 1'b0;
          end
        end
        ST_LOW: begin
          if (req0.start) waiting <= 1'b1;
          if (!waiting && (nin == 2'd0 || nin == 2'd3) || rsp0.done) begin
            waiting <= 1'b0;
            work[0] <= res0;
            work[1] <= res1;
            nwork <= nres;
            widx <= '0;
          end
        end
        ST_UPPER: begin
          if (widx < nwork) begin
            if (req0.start) waiting <= 1'b1;
            if (!waiting && (nin == 2'd0 || nin == 2'd3) || rsp0.done) begin
              waiting <= 1'b0;
              if (nres != 2'd0) outq[nout[1:0]] <= res0;
              if (nres == 2'd2) outq[2'(nout + 3'd1)] <= res1;
              nout <= nout + 3'(nres);
              widx <= widx + 2'd1;
            end
          end
        end
        ST_EMIT: begin
          if (out_valid && !out_stall) begin
            ridx <= ridx + 2'd1;
            nfin <= nfin + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  `TSC_ASSERT_NOW(a_lanes_pair, clk, rst, rsp0.done, rsp1.done)
  `TSC_ASSERT_NOW(a_out_count, clk, rst, out_valid, nout <= 3'd4)
  `TSC_ASSERT_NOW(a_emit_only, clk, rst, out_valid, state == ST_EMIT)
endmodule
